/* rtl/lis_pkg.sv */
// ---------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the indexed list store.
// ---------------------------------------------------------------------------
package lis_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 7;
    localparam int GROUP       = 8;
    localparam int NGROUP      = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic [VALUE_WIDTH-1:0] lis_word_t;
    typedef logic [POS_W-1:0]       lis_pos_t;

    typedef enum logic [2:0] {
        OP_ADD_FIRST = 3'd0,
        OP_ADD_LAST  = 3'd1,
        OP_INSERT_AT = 3'd2,
        OP_SET_AT    = 3'd3,
        OP_GET_AT    = 3'd4,
        OP_REMOVE_AT = 3'd5,
        OP_SWAP      = 3'd6,
        OP_CLEAR     = 3'd7
    } lis_op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } lis_err_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE,
        CELL_SWAP
    } lis_cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_REDUCE,
        ST_COMMIT
    } lis_state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [6:0]         position;
        logic [5:0]         other_position;
        logic signed [31:0] item_value;
    } lis_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic [1:0]         error_code;
    } lis_out_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        lis_cell_op_t kind;
        lis_pos_t     pos;
        lis_pos_t     pos2;
        lis_word_t    wr_value;
        lis_word_t    swap_a;
        lis_word_t    swap_b;
    } lis_cell_cmd_t;

endpackage

/* rtl/lis_cell.sv */
// ---------------------------------------------------------------------------
// lis_cell
// One list entry: shifts from a neighbour, takes a write or a swap value,
// and offers its word to the two read ports when its index matches.
// ---------------------------------------------------------------------------
module lis_cell
    import lis_pkg::*;
(
    input  logic          aclk,
    input  lis_pos_t      cell_index,
    input  lis_cell_cmd_t cmd,
    input  lis_word_t     left_value,
    input  lis_word_t     right_value,
    output lis_word_t     entry_value,
    output lis_word_t     rd_a,
    output lis_word_t     rd_b
);

    lis_word_t entry_reg;
    lis_word_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.kind)
            CELL_SHIFT_UP: begin
                if (cell_index > cmd.pos) begin
                    entry_next = left_value;
                end else if (cell_index == cmd.pos) begin
                    entry_next = cmd.wr_value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (cell_index >= cmd.pos) begin
                    entry_next = right_value;
                end
            end
            CELL_WRITE: begin
                if (cell_index == cmd.pos) begin
                    entry_next = cmd.wr_value;
                end
            end
            CELL_SWAP: begin
                if (cell_index == cmd.pos) begin
                    entry_next = cmd.swap_b;
                end else if (cell_index == cmd.pos2) begin
                    entry_next = cmd.swap_a;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;
    assign rd_a = (cell_index == cmd.pos)  ? entry_reg : '0;
    assign rd_b = (cell_index == cmd.pos2) ? entry_reg : '0;

endmodule

/* rtl/lis_gather.sv */
// ---------------------------------------------------------------------------
// lis_gather
// Two-level registered OR tree collecting the matching cell word for
// each of the two read ports.
// ---------------------------------------------------------------------------
module lis_gather
    import lis_pkg::*;
(
    input  logic                       aclk,
    input  lis_word_t [CAPACITY-1:0]   cell_a,
    input  lis_word_t [CAPACITY-1:0]   cell_b,
    output lis_word_t                  rd_a,
    output lis_word_t                  rd_b
);

    lis_word_t [NGROUP-1:0] grp_a_reg, grp_a_next;
    lis_word_t [NGROUP-1:0] grp_b_reg, grp_b_next;
    lis_word_t              rd_a_reg, rd_a_next;
    lis_word_t              rd_b_reg, rd_b_next;

    // at most one cell matches each port, so OR acts as the select
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_a_next[g] = '0;
            grp_b_next[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    grp_a_next[g] = grp_a_next[g] | cell_a[g * GROUP + k];
                    grp_b_next[g] = grp_b_next[g] | cell_b[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        rd_a_next = '0;
        rd_b_next = '0;
        for (int g = 0; g < NGROUP; g++) begin
            rd_a_next = rd_a_next | grp_a_reg[g];
            rd_b_next = rd_b_next | grp_b_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        grp_a_reg <= grp_a_next;
        grp_b_reg <= grp_b_next;
        rd_a_reg  <= rd_a_next;
        rd_b_reg  <= rd_b_next;
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

/* rtl/indexed_list_store.sv */
// ---------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list with positional add, insert, set, get, remove,
// swap and clear; one result transaction per command.
// ---------------------------------------------------------------------------
// The list lives in a chain of 64 cells, one word each; inserts and removes
// move every later entry one cell along in the same cycle. A command that
// writes or fails passes through the issue state before the next acceptance;
// get_at and swap also pass through the reduce and commit states, as the read
// passes through a two-level registered OR tree over all cells. A held
// result does not stop the next command from being accepted; only the commit
// of that command waits for the output register to drain. Entries beyond the
// count hold stale data and are never read out.
module indexed_list_store
    import lis_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lis_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lis_out_t m_data
);

    lis_state_t state_reg, state_next;
    lis_in_t    cmd_reg;
    lis_pos_t   count_reg, count_next;
    logic       m_valid_reg;
    lis_out_t   m_data_reg;

    lis_err_t     err;
    lis_cell_op_t kind;
    lis_pos_t     op_pos;
    lis_pos_t     count_calc;
    logic         needs_read;
    logic         slot_free;
    logic         commit;
    lis_pos_t     pos2;

    lis_cell_cmd_t             cell_cmd;
    lis_word_t [CAPACITY-1:0]  cell_value;
    lis_word_t [CAPACITY-1:0]  cell_rd_a;
    lis_word_t [CAPACITY-1:0]  cell_rd_b;
    lis_word_t                 rd_a;
    lis_word_t                 rd_b;

    assign pos2      = POS_W'(cmd_reg.other_position);
    assign slot_free = !m_valid_reg || m_ready;

    // decode and range checks against the committed count
    always_comb begin
        err        = ERR_OK;
        kind       = CELL_HOLD;
        op_pos     = cmd_reg.position;
        count_calc = count_reg;
        needs_read = 1'b0;
        case (cmd_reg.opcode)
            OP_ADD_FIRST: begin
                op_pos = '0;
                if (count_reg == POS_W'(CAPACITY)) begin
                    err = ERR_FULL;
                end else begin
                    kind       = CELL_SHIFT_UP;
                    count_calc = count_reg + POS_W'(1);
                end
            end
            OP_ADD_LAST: begin
                op_pos = count_reg;
                if (count_reg == POS_W'(CAPACITY)) begin
                    err = ERR_FULL;
                end else begin
                    kind       = CELL_WRITE;
                    count_calc = count_reg + POS_W'(1);
                end
            end
            OP_INSERT_AT: begin
                if (cmd_reg.position > count_reg) begin
                    err = ERR_RANGE;
                end else if (count_reg == POS_W'(CAPACITY)) begin
                    err = ERR_FULL;
                end else begin
                    kind       = CELL_SHIFT_UP;
                    count_calc = count_reg + POS_W'(1);
                end
            end
            OP_SET_AT: begin
                if (cmd_reg.position >= count_reg) begin
                    err = ERR_RANGE;
                end else begin
                    kind = CELL_WRITE;
                end
            end
            OP_GET_AT: begin
                if (cmd_reg.position >= count_reg) begin
                    err = ERR_RANGE;
                end else begin
                    needs_read = 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (cmd_reg.position >= count_reg) begin
                    err = ERR_RANGE;
                end else begin
                    kind       = CELL_SHIFT_DOWN;
                    count_calc = count_reg - POS_W'(1);
                end
            end
            OP_SWAP: begin
                if (cmd_reg.position >= count_reg || pos2 >= count_reg) begin
                    err = ERR_RANGE;
                end else begin
                    kind       = CELL_SWAP;
                    needs_read = 1'b1;
                end
            end
            OP_CLEAR: begin
                count_calc = '0;
            end
            default: begin
                err = ERR_OK;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (needs_read) begin
                    state_next = ST_REDUCE;
                end else if (slot_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (slot_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign count_next = commit ? count_calc : count_reg;

    always_comb begin
        cell_cmd.kind     = commit ? kind : CELL_HOLD;
        cell_cmd.pos      = op_pos;
        cell_cmd.pos2     = pos2;
        cell_cmd.wr_value = cmd_reg.item_value;
        cell_cmd.swap_a   = rd_a;
        cell_cmd.swap_b   = rd_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
        if (commit) begin
            m_data_reg.read_value  <= (cmd_reg.opcode == OP_GET_AT && err == ERR_OK)
                                      ? rd_a : '0;
            m_data_reg.entry_count <= count_calc;
            m_data_reg.is_empty    <= (count_calc == '0);
            m_data_reg.error_code  <= err;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lis_word_t left_value;
        lis_word_t right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_right
            assign right_value = cell_value[i+1];
        end

        lis_cell u_cell (
            .aclk        (aclk),
            .cell_index  (POS_W'(i)),
            .cmd         (cell_cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .entry_value (cell_value[i]),
            .rd_a        (cell_rd_a[i]),
            .rd_b        (cell_rd_b[i])
        );
    end

    lis_gather u_gather (
        .aclk   (aclk),
        .cell_a (cell_rd_a),
        .cell_b (cell_rd_b),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + POS_W'(1) ||
                                 count_reg == $past(count_reg) - POS_W'(1) ||
                                 count_reg == '0))
        else $error("entry count moved by more than one");

    a_fail_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && err != ERR_OK) |=> $stable(count_reg))
        else $error("failed command changed the count");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_valid && m_data.entry_count == count_reg))
        else $error("committed result not presented with new count");

    a_accept_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_ISSUE))
        else $error("accepted transaction not issued");
`endif

endmodule
